>>> rtl/core/wiegand_format_decoder_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the card format decoder core
// Concurrent property shorthands that share one clock and reset.
// ----------------------------------------------------------------------------
`ifndef WIEGAND_FORMAT_DECODER_CORE_MACROS_SVH
`define WIEGAND_FORMAT_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define WFD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wfd core: same-cycle property failed");

// Next-cycle implication, disabled while reset is high
`define WFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wfd core: next-cycle property failed");

`endif

>>> rtl/core/wfd_pkg.sv
// ----------------------------------------------------------------------------
// wfd_pkg
// Types, codes and the fixed card layout table of the format decoder.
// ----------------------------------------------------------------------------
package wfd_pkg;

  // Container and match limits
  localparam int CONTAINER_BITS = 48;
  localparam int MAX_MATCHES    = 2;
  localparam int NUM_FORMATS    = 10;

  // Field widths
  localparam int LEN_W   = 6;
  localparam int IDX_W   = 4;
  localparam int FAC_W   = 18;
  localparam int CARD_W  = 35;
  localparam int SCORE_W = 8;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_AMBIGUITY_MARGIN      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PARITY_BONUS          = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PARITY_PENALTY        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_CONFIDENCE_SCORE = 3'd3;

  localparam logic [CFG_DATA_W-1:0] RST_AMBIGUITY_MARGIN      = 8'd15;
  localparam logic [CFG_DATA_W-1:0] RST_PARITY_BONUS          = 8'd25;
  localparam logic [CFG_DATA_W-1:0] RST_PARITY_PENALTY        = 8'd30;
  localparam logic [CFG_DATA_W-1:0] RST_HIGH_CONFIDENCE_SCORE = 8'd85;

  // Parity outcome codes
  localparam logic [1:0] PARITY_UNKNOWN = 2'd0;
  localparam logic [1:0] PARITY_VALID   = 2'd1;
  localparam logic [1:0] PARITY_INVALID = 2'd2;

  // Confidence codes
  localparam logic [1:0] CONF_LOW    = 2'd0;
  localparam logic [1:0] CONF_MEDIUM = 2'd1;
  localparam logic [1:0] CONF_HIGH   = 2'd2;

  // Three-mask parity masks over the low 32 bits
  localparam logic [31:0] MASK3_A = 32'hB6DB6DB6;
  localparam logic [31:0] MASK3_B = 32'h6DB6DB6C;

  // Container sentinel search
  localparam int LEAD_BITS     = 6;
  localparam int SENTINEL_LEN  = 37;
  localparam int SHORT_MAX_LEN = 36;
  localparam int SHORT_MIN_LEN = 26;

  typedef enum logic [1:0] {
    SCHEME_NONE,
    SCHEME_PAIR,
    SCHEME_MASK3
  } scheme_t;

  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   foff;
    logic [LEN_W-1:0]   flen;
    logic [LEN_W-1:0]   coff;
    logic [LEN_W-1:0]   clen;
    scheme_t            scheme;
    logic [LEN_W-1:0]   pa_bit;
    logic [LEN_W-1:0]   pa_off;
    logic [LEN_W-1:0]   pa_len;
    logic               pa_odd;
    logic [LEN_W-1:0]   pb_bit;
    logic [LEN_W-1:0]   pb_off;
    logic [LEN_W-1:0]   pb_len;
    logic               pb_odd;
    logic [SCORE_W-1:0] base;
  } layout_t;

  // len foff flen coff clen scheme pa_bit pa_off pa_len pa_odd pb_bit pb_off pb_len pb_odd base
  localparam layout_t LAYOUT_ROM [NUM_FORMATS] = '{
    '{6'd26, 6'd1, 6'd8,  6'd9,  6'd16, SCHEME_PAIR,  6'd0, 6'd1, 6'd12, 1'b0,
      6'd25, 6'd13, 6'd12, 1'b1, 8'd70},
    '{6'd32, 6'd0, 6'd8,  6'd8,  6'd24, SCHEME_NONE,  6'd0, 6'd0, 6'd0,  1'b0,
      6'd0,  6'd0,  6'd0,  1'b0, 8'd35},
    '{6'd32, 6'd0, 6'd12, 6'd12, 6'd20, SCHEME_NONE,  6'd0, 6'd0, 6'd0,  1'b0,
      6'd0,  6'd0,  6'd0,  1'b0, 8'd35},
    '{6'd34, 6'd1, 6'd16, 6'd17, 6'd16, SCHEME_PAIR,  6'd0, 6'd1, 6'd16, 1'b0,
      6'd33, 6'd17, 6'd16, 1'b1, 8'd65},
    '{6'd35, 6'd2, 6'd12, 6'd14, 6'd20, SCHEME_MASK3, 6'd0, 6'd0, 6'd0,  1'b0,
      6'd0,  6'd0,  6'd0,  1'b0, 8'd67},
    '{6'd36, 6'd1, 6'd18, 6'd19, 6'd16, SCHEME_NONE,  6'd0, 6'd0, 6'd0,  1'b0,
      6'd0,  6'd0,  6'd0,  1'b0, 8'd35},
    '{6'd37, 6'd0, 6'd0,  6'd1,  6'd35, SCHEME_PAIR,  6'd0, 6'd1, 6'd18, 1'b0,
      6'd36, 6'd18, 6'd18, 1'b1, 8'd55},
    '{6'd37, 6'd1, 6'd16, 6'd17, 6'd19, SCHEME_PAIR,  6'd0, 6'd1, 6'd18, 1'b0,
      6'd36, 6'd18, 6'd18, 1'b1, 8'd60},
    '{6'd40, 6'd0, 6'd8,  6'd8,  6'd32, SCHEME_NONE,  6'd0, 6'd0, 6'd0,  1'b0,
      6'd0,  6'd0,  6'd0,  1'b0, 8'd35},
    '{6'd40, 6'd0, 6'd16, 6'd16, 6'd24, SCHEME_NONE,  6'd0, 6'd0, 6'd0,  1'b0,
      6'd0,  6'd0,  6'd0,  1'b0, 8'd35}
  };

  // Credential word
  typedef struct packed {
    logic                      op;
    logic [CONTAINER_BITS-1:0] raw_bits;
    logic [LEN_W-1:0]          given_length;
  } cred_word_t;

  // Result word
  typedef struct packed {
    logic [IDX_W-1:0]   format_index;
    logic [FAC_W-1:0]   facility_code;
    logic [CARD_W-1:0]  card_number;
    logic [1:0]         parity_status;
    logic [SCORE_W-1:0] score;
    logic               ambiguous;
    logic [1:0]         confidence;
    logic [LEN_W-1:0]   decoded_length;
    logic               found;
    logic               last;
  } result_word_t;

endpackage

>>> rtl/core/wfd_cred_if.sv
// ----------------------------------------------------------------------------
// wfd_cred_if
// Valid/ready channel carrying one credential word.
// ----------------------------------------------------------------------------
interface wfd_cred_if;
  logic                valid;
  logic                ready;
  wfd_pkg::cred_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/wfd_result_if.sv
// ----------------------------------------------------------------------------
// wfd_result_if
// Valid/ready channel carrying one decode result word.
// ----------------------------------------------------------------------------
interface wfd_result_if;
  logic                  valid;
  logic                  ready;
  wfd_pkg::result_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/wiegand_format_decoder_core.sv
// ----------------------------------------------------------------------------
// wiegand_format_decoder_core
// Card format decoder: layout match, field extraction, parity scoring, sort.
// ----------------------------------------------------------------------------
//  channel      dir  payload                      handshake
//  credential   in   op, raw_bits, given_length   valid/ready
//  result       out  result_word_t                valid/ready, last ends a run
//  wr_*         in   register index, 8-bit data   write on wr_en, no stall
//
//  A credential is registered in the input register, decoded combinationally
//  and loaded into a two-word result buffer, which presents the first word.
//  The result port moves one word per cycle while result.ready is high; a
//  credential with one match yields one word and one with two yields two.
//  Reset clears only the valid flags, the word pointer and the configuration registers; no clearing pass.
//  A stalled result holds the buffer; one further credential waits in the
//  input register while the buffer drains.
// ----------------------------------------------------------------------------
`include "wiegand_format_decoder_core_macros.svh"

module wiegand_format_decoder_core (
  input  logic                                clk,
  input  logic                                rst,
  wfd_cred_if.sink                            credential,
  wfd_result_if.source                        result,
  input  logic                                wr_en,
  input  logic [wfd_pkg::CFG_INDEX_W-1:0]     wr_index,
  input  logic [wfd_pkg::CFG_DATA_W-1:0]      wr_data
);

  localparam int CB = wfd_pkg::CONTAINER_BITS;

  // Configuration registers
  logic [wfd_pkg::CFG_DATA_W-1:0] ambiguity_margin;
  logic [wfd_pkg::CFG_DATA_W-1:0] parity_bonus;
  logic [wfd_pkg::CFG_DATA_W-1:0] parity_penalty;
  logic [wfd_pkg::CFG_DATA_W-1:0] high_confidence_score;

  // Input register
  logic                in_valid;
  logic                in_ready;
  wfd_pkg::cred_word_t in_word;

  // Result buffer
  logic                  res_valid;
  logic                  res_sel;
  logic                  res_last;
  logic                  out_fire;
  logic                  load;
  wfd_pkg::result_word_t res_slot [2];

  // Decode path
  logic [wfd_pkg::LEN_W-1:0]   dec_len;
  logic [wfd_pkg::FAC_W-1:0]   cand_fac   [wfd_pkg::NUM_FORMATS];
  logic [wfd_pkg::CARD_W-1:0]  cand_card  [wfd_pkg::NUM_FORMATS];
  logic [1:0]                  cand_par   [wfd_pkg::NUM_FORMATS];
  logic [wfd_pkg::SCORE_W-1:0] cand_score [wfd_pkg::NUM_FORMATS];
  logic                        have0;
  logic                        have1;
  logic [wfd_pkg::IDX_W-1:0]   sel0;
  logic [wfd_pkg::IDX_W-1:0]   sel1;
  wfd_pkg::result_word_t       word0;
  wfd_pkg::result_word_t       word1;

  // Field at a bit offset counted from the first transmitted bit
  function automatic logic [CB-1:0] field_bits(input logic [CB-1:0] raw,
                                               input logic [wfd_pkg::LEN_W-1:0] len,
                                               input logic [wfd_pkg::LEN_W-1:0] off,
                                               input logic [wfd_pkg::LEN_W-1:0] flen);
    logic [CB-1:0] mask;
    mask = ({{(CB-1){1'b0}}, 1'b1} << flen) - {{(CB-1){1'b0}}, 1'b1};
    field_bits = (raw >> (len - off - flen)) & mask;
  endfunction

  // Parity bit against a contiguous run of covered bits
  function automatic logic pair_ok(input logic [CB-1:0] raw,
                                   input logic [wfd_pkg::LEN_W-1:0] len,
                                   input logic [wfd_pkg::LEN_W-1:0] pbit,
                                   input logic [wfd_pkg::LEN_W-1:0] off,
                                   input logic [wfd_pkg::LEN_W-1:0] n,
                                   input logic odd);
    logic [CB-1:0]             mask;
    logic [wfd_pkg::LEN_W-1:0] pos;
    logic                      ones;
    mask = (({{(CB-1){1'b0}}, 1'b1} << n) - {{(CB-1){1'b0}}, 1'b1}) << (len - off - n);
    pos  = len - 6'd1 - pbit;
    ones = raw[pos] ^ (^(raw & mask));
    pair_ok = (ones == odd);
  endfunction

  // Three interleaved parity masks of the 35-bit layout
  function automatic logic mask3_ok(input logic [CB-1:0] raw);
    logic ea;
    logic eb;
    logic ec;
    ea = raw[32] ^ (^(raw[31:0] & wfd_pkg::MASK3_A));
    eb = raw[32] ^ raw[33] ^ (^(raw[31:0] & wfd_pkg::MASK3_B)) ^ 1'b1;
    ec = raw[32] ^ raw[33] ^ (^raw[31:0]) ^ 1'b1;
    mask3_ok = (raw[33] == ea) && (raw[0] == eb) && (raw[34] == ec);
  endfunction

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ambiguity_margin      <= wfd_pkg::RST_AMBIGUITY_MARGIN;
      parity_bonus          <= wfd_pkg::RST_PARITY_BONUS;
      parity_penalty        <= wfd_pkg::RST_PARITY_PENALTY;
      high_confidence_score <= wfd_pkg::RST_HIGH_CONFIDENCE_SCORE;
    end else if (wr_en) begin
      unique case (wr_index)
        wfd_pkg::REG_AMBIGUITY_MARGIN:      ambiguity_margin      <= wr_data;
        wfd_pkg::REG_PARITY_BONUS:          parity_bonus          <= wr_data;
        wfd_pkg::REG_PARITY_PENALTY:        parity_penalty        <= wr_data;
        wfd_pkg::REG_HIGH_CONFIDENCE_SCORE: high_confidence_score <= wr_data;
        default: ;
      endcase
    end
  end

  // Derive the credential length; container sentinel search when op is set
  always_comb begin
    dec_len = '0;
    if (!in_word.op) begin
      dec_len = in_word.given_length;
    end else if (|in_word.raw_bits[CB-1:CB-wfd_pkg::LEAD_BITS]) begin
      dec_len = '0;
    end else if (!in_word.raw_bits[CB-1-wfd_pkg::LEAD_BITS]) begin
      dec_len = wfd_pkg::LEN_W'(wfd_pkg::SENTINEL_LEN);
    end else begin
      // lowest offset wins, so scan from the far end
      for (int k = wfd_pkg::LEAD_BITS + 1 + wfd_pkg::SHORT_MAX_LEN - wfd_pkg::SHORT_MIN_LEN;
           k >= wfd_pkg::LEAD_BITS + 1; k--) begin
        if (in_word.raw_bits[CB-1-k]) begin
          dec_len = wfd_pkg::LEN_W'(wfd_pkg::SHORT_MAX_LEN + wfd_pkg::LEAD_BITS + 1 - k);
        end
      end
    end
  end

  // Extract fields and score every layout in parallel
  always_comb begin
    wfd_pkg::layout_t lay;
    logic [wfd_pkg::SCORE_W:0] sum;
    logic                      ok;
    for (int i = 0; i < wfd_pkg::NUM_FORMATS; i++) begin
      lay = wfd_pkg::LAYOUT_ROM[i];
      cand_fac[i]  = wfd_pkg::FAC_W'(field_bits(in_word.raw_bits, lay.len, lay.foff, lay.flen));
      cand_card[i] = wfd_pkg::CARD_W'(field_bits(in_word.raw_bits, lay.len, lay.coff,
                                                 lay.clen));
      ok  = 1'b0;
      sum = {1'b0, lay.base} + {1'b0, parity_bonus};
      unique case (lay.scheme)
        wfd_pkg::SCHEME_PAIR: begin
          ok = pair_ok(in_word.raw_bits, lay.len, lay.pa_bit, lay.pa_off, lay.pa_len,
                       lay.pa_odd) &&
               pair_ok(in_word.raw_bits, lay.len, lay.pb_bit, lay.pb_off, lay.pb_len,
                       lay.pb_odd);
        end
        wfd_pkg::SCHEME_MASK3: ok = mask3_ok(in_word.raw_bits);
        default:               ok = 1'b0;
      endcase
      if (lay.scheme == wfd_pkg::SCHEME_NONE) begin
        cand_par[i]   = wfd_pkg::PARITY_UNKNOWN;
        cand_score[i] = lay.base;
      end else if (ok) begin
        cand_par[i]   = wfd_pkg::PARITY_VALID;
        cand_score[i] = sum[wfd_pkg::SCORE_W] ? '1 : sum[wfd_pkg::SCORE_W-1:0];
      end else begin
        cand_par[i]   = wfd_pkg::PARITY_INVALID;
        cand_score[i] = (lay.base > parity_penalty) ? lay.base - parity_penalty : '0;
      end
    end
  end

  // Pick the first matching layouts in table order
  always_comb begin
    have0 = 1'b0;
    have1 = 1'b0;
    sel0  = '0;
    sel1  = '0;
    for (int i = 0; i < wfd_pkg::NUM_FORMATS; i++) begin
      if (wfd_pkg::LAYOUT_ROM[i].len == dec_len) begin
        if (!have0) begin
          have0 = 1'b1;
          sel0  = wfd_pkg::IDX_W'(i);
        end else if (!have1 && (wfd_pkg::MAX_MATCHES > 1)) begin
          have1 = 1'b1;
          sel1  = wfd_pkg::IDX_W'(i);
        end
      end
    end
  end

  // Order the matches by score, keep table order on ties, and flag the run
  always_comb begin
    wfd_pkg::result_word_t     ma;
    wfd_pkg::result_word_t     mb;
    logic [wfd_pkg::SCORE_W-1:0] gap;
    logic                      amb;
    logic [1:0]                conf;
    ma = '0;
    mb = '0;
    ma.format_index  = sel0;
    ma.facility_code = cand_fac[sel0];
    ma.card_number   = cand_card[sel0];
    ma.parity_status = cand_par[sel0];
    ma.score         = cand_score[sel0];
    mb.format_index  = sel1;
    mb.facility_code = cand_fac[sel1];
    mb.card_number   = cand_card[sel1];
    mb.parity_status = cand_par[sel1];
    mb.score         = cand_score[sel1];
    if (have1 && (mb.score > ma.score)) begin
      word0 = mb;
      word1 = ma;
    end else begin
      word0 = ma;
      word1 = mb;
    end
    gap  = word0.score - word1.score;
    amb  = have1 && (gap < ambiguity_margin);
    conf = amb ? wfd_pkg::CONF_LOW :
           (word0.score >= high_confidence_score) ? wfd_pkg::CONF_HIGH : wfd_pkg::CONF_MEDIUM;
    word0.ambiguous      = amb;
    word0.confidence     = conf;
    word0.decoded_length = dec_len;
    word0.found          = 1'b1;
    word0.last           = !have1;
    word1.ambiguous      = amb;
    word1.confidence     = conf;
    word1.decoded_length = dec_len;
    word1.found          = 1'b1;
    word1.last           = 1'b1;
    // no match: a single zero word, with only last set, that ends the run
    if (!have0) begin
      word0      = '0;
      word0.last = 1'b1;
    end
  end

  // Handshake: load the buffer when empty or when its last word leaves
  assign res_last   = res_sel ? res_slot[1].last : res_slot[0].last;
  assign out_fire   = res_valid && result.ready;
  assign load       = in_valid && (!res_valid || (out_fire && res_last));
  assign in_ready   = !in_valid || load;

  assign credential.ready = in_ready;
  assign result.valid     = res_valid;
  assign result.data      = res_sel ? res_slot[1] : res_slot[0];

  // Advance the valid flags and the word pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      res_valid <= 1'b0;
      res_sel   <= 1'b0;
    end else begin
      if (credential.valid && in_ready) begin
        in_valid <= 1'b1;
      end else if (load) begin
        in_valid <= 1'b0;
      end
      if (load) begin
        res_valid <= 1'b1;
        res_sel   <= 1'b0;
      end else if (out_fire) begin
        if (res_last) begin
          res_valid <= 1'b0;
        end else begin
          res_sel <= 1'b1;
        end
      end
    end
  end

  // Capture payloads
  always_ff @(posedge clk) begin
    if (credential.valid && in_ready) begin
      in_word <= credential.data;
    end
    if (load) begin
      res_slot[0] <= word0;
      res_slot[1] <= word1;
    end
  end

  // Checks
  `WFD_ASSERT_IMPLIES(a_nomatch_last, clk, rst, result.valid && !result.data.found, result.data.last)
  `WFD_ASSERT_NEXT(a_second_follows, clk, rst, out_fire && !res_last, result.valid && res_last)
  `WFD_ASSERT_IMPLIES(a_found_len, clk, rst, result.valid && result.data.found, result.data.decoded_length != 6'd0)
  `WFD_ASSERT_IMPLIES(a_amb_low, clk, rst, result.valid && result.data.ambiguous, result.data.confidence == wfd_pkg::CONF_LOW)

endmodule
